// ----- sv/isst_pkg.sv -----
// Shared constants, codes and control types for the indexed sequence store.
// Used by the interfaces, the controller, the datapath and the top level.
package isst_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int CMD_W    = 3;
  localparam int ST_W     = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // What the decoded command needs from the sequencer
  typedef enum logic [1:0] {
    K_READ,
    K_PLACE,
    K_REMOVE,
    K_RESULT
  } isst_kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic start;
    logic rd_pos;
    logic rd_move;
    logic wr_move;
    logic wr_value;
    logic finish;
  } isst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    isst_kind_t kind;
    logic       more;
    logic       out_busy;
  } isst_sts_t;

endpackage

// ----- sv/isst_if.sv -----
// Valid/ready channel interfaces for command items and result items.
// Depends on isst_pkg for field widths.
interface isst_in_if;
  logic                          valid;
  logic                          ready;
  logic [isst_pkg::CMD_W-1:0]    cmd;
  logic [isst_pkg::POS_W-1:0]    position;
  logic signed [isst_pkg::DATA_W-1:0] item_value;

  modport source (output valid, cmd, position, item_value, input ready);
  modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

interface isst_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [isst_pkg::DATA_W-1:0] read_value;
  logic [isst_pkg::ST_W-1:0]     status;
  logic [isst_pkg::POS_W-1:0]    stored_count;

  modport source (output valid, read_value, status, stored_count, input ready);
  modport sink   (input valid, read_value, status, stored_count, output ready);
endinterface

// ----- sv/indexed_sequence_store_top.sv -----
// Indexed sequence store: an ordered list of signed 32-bit values held in an
// element memory with one write port and one registered read port, edited by
// position. One command item is taken at a time. After decode, a rejected
// command or a spare code goes straight to the result, a read fetches the
// value, and an add, insert or delete sweeps the values that shift, each
// costing a read, a write and a loop check; an add or insert then writes the
// new value. The next command item can be taken in the same cycle as the
// result goes valid. A finished result waits in an output register while
// the next command item is accepted; a result that is still unclaimed when
// the next one finishes holds the block.
// No clearing pass is needed after reset.
// Depends on isst_pkg, isst_if, isst_ctrl and isst_dp.
module indexed_sequence_store_top (
  input  logic              clk,
  input  logic              rst_n,
  isst_in_if.sink           in_ch,
  isst_out_if.source        out_ch
);

  isst_pkg::isst_cmd_t cmd;
  isst_pkg::isst_sts_t sts;

  isst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  isst_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_cmd           (in_ch.cmd),
    .in_position      (in_ch.position),
    .in_item_value    (in_ch.item_value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_read_value   (out_ch.read_value),
    .out_status       (out_ch.status),
    .out_stored_count (out_ch.stored_count)
  );

  // The block goes busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input still ready after an item was taken");

  // Memory accesses are issued one kind per cycle
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rd_pos, cmd.rd_move, cmd.wr_move, cmd.wr_value, cmd.finish}))
    else $error("conflicting memory commands");

  // A result is only pushed when the output register is free
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrote a pending item");

endmodule

// ----- sv/isst_ctrl.sv -----
// Sequencer for the indexed sequence store: steps each command through
// decode, the element move sweep and result delivery. Depends on isst_pkg.
module isst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  isst_pkg::isst_sts_t sts,
  output isst_pkg::isst_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_LOOP,
    S_MV_RD,
    S_MV_WR,
    S_PLACE,
    S_RD,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        case (sts.kind)
          isst_pkg::K_READ:   state_nxt = S_RD;
          isst_pkg::K_PLACE:  state_nxt = S_LOOP;
          isst_pkg::K_REMOVE: state_nxt = S_LOOP;
          default:            state_nxt = S_FIN;
        endcase
      end
      S_LOOP: begin
        if (sts.more) state_nxt = S_MV_RD;
        else if (sts.kind == isst_pkg::K_PLACE) state_nxt = S_PLACE;
        else state_nxt = S_FIN;
      end
      S_MV_RD: state_nxt = S_MV_WR;
      S_MV_WR: state_nxt = S_LOOP;
      S_PLACE: state_nxt = S_FIN;
      S_RD:    state_nxt = S_FIN;
      S_FIN: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive datapath commands from the current state
  always_comb begin
    in_ready     = (state_r == S_IDLE);
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.start    = (state_r == S_DECIDE);
    cmd.rd_pos   = (state_r == S_RD);
    cmd.rd_move  = (state_r == S_MV_RD);
    cmd.wr_move  = (state_r == S_MV_WR);
    cmd.wr_value = (state_r == S_PLACE);
    cmd.finish   = (state_r == S_FIN) && !sts.out_busy;
  end

endmodule

// ----- sv/isst_dp.sv -----
// Datapath for the indexed sequence store: element memory, count, sweep
// index, command decode and the result register. Depends on isst_pkg.
module isst_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  isst_pkg::isst_cmd_t                cmd,
  output isst_pkg::isst_sts_t                sts,
  input  logic [isst_pkg::CMD_W-1:0]         in_cmd,
  input  logic [isst_pkg::POS_W-1:0]         in_position,
  input  logic signed [isst_pkg::DATA_W-1:0] in_item_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [isst_pkg::DATA_W-1:0] out_read_value,
  output logic [isst_pkg::ST_W-1:0]          out_status,
  output logic [isst_pkg::POS_W-1:0]         out_stored_count
);

  localparam int CW = isst_pkg::CNT_W;
  localparam int AW = isst_pkg::ADDR_W;
  localparam int MW = isst_pkg::CMP_W;

  logic [isst_pkg::DATA_W-1:0] mem [isst_pkg::CAPACITY];

  logic [isst_pkg::CMD_W-1:0]  cmd_r;
  logic [isst_pkg::POS_W-1:0]  pos_r;
  logic [isst_pkg::DATA_W-1:0] val_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r;
  logic [CW-1:0]               tgt_r;
  isst_pkg::isst_kind_t        kind_r;
  logic [isst_pkg::ST_W-1:0]   st_r;
  logic [isst_pkg::DATA_W-1:0] rv_r;
  logic [isst_pkg::DATA_W-1:0] rdata_r;
  logic                        out_valid_r;
  logic [isst_pkg::DATA_W-1:0] out_rv_r;
  logic [isst_pkg::ST_W-1:0]   out_st_r;
  logic [isst_pkg::POS_W-1:0]  out_cnt_r;

  // Decode results
  isst_pkg::isst_kind_t        kind_c;
  logic [MW-1:0]               tgt_c;
  logic [isst_pkg::ST_W-1:0]   st_c;
  logic [isst_pkg::DATA_W-1:0] rv_c;
  logic [MW-1:0]               pos_w;
  logic [MW-1:0]               cnt_w;
  logic                        full;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               waddr;
  logic [isst_pkg::DATA_W-1:0] wdata;
  logic                        wen;
  logic                        ren;
  logic [CW:0]                 idx_inc;

  // Classify the held command against the current count
  always_comb begin
    pos_w  = MW'(pos_r);
    cnt_w  = MW'(count_r);
    full   = (count_r == CW'(isst_pkg::CAPACITY));
    kind_c = isst_pkg::K_RESULT;
    tgt_c  = '0;
    st_c   = isst_pkg::ST_DONE;
    rv_c   = '0;
    case (cmd_r)
      isst_pkg::CMD_READ: begin
        if (pos_w < cnt_w) begin
          kind_c = isst_pkg::K_READ;
          tgt_c  = pos_w;
        end else begin
          rv_c = '1;
          st_c = isst_pkg::ST_RANGE;
        end
      end
      isst_pkg::CMD_ADD_HEAD: begin
        if (full) st_c = isst_pkg::ST_FULL;
        else kind_c = isst_pkg::K_PLACE;
      end
      isst_pkg::CMD_ADD_TAIL: begin
        if (full) begin
          st_c = isst_pkg::ST_FULL;
        end else begin
          kind_c = isst_pkg::K_PLACE;
          tgt_c  = cnt_w;
        end
      end
      isst_pkg::CMD_INSERT: begin
        if (pos_w > cnt_w) begin
          st_c = isst_pkg::ST_RANGE;
        end else if (full) begin
          st_c = isst_pkg::ST_FULL;
        end else begin
          kind_c = isst_pkg::K_PLACE;
          tgt_c  = pos_w;
        end
      end
      isst_pkg::CMD_DELETE: begin
        if (pos_w >= cnt_w) begin
          st_c = isst_pkg::ST_RANGE;
        end else begin
          kind_c = isst_pkg::K_REMOVE;
          tgt_c  = pos_w;
        end
      end
      default: begin
        kind_c = isst_pkg::K_RESULT;
      end
    endcase
  end

  // Memory address and data selection for the sweep
  always_comb begin
    idx_inc = {1'b0, idx_r} + 1'b1;
    if (cmd.rd_pos) raddr = tgt_r[AW-1:0];
    else if (kind_r == isst_pkg::K_PLACE) raddr = AW'(idx_r - 1'b1);
    else raddr = idx_inc[AW-1:0];
    ren   = cmd.rd_pos || cmd.rd_move;
    wen   = cmd.wr_move || cmd.wr_value;
    waddr = cmd.wr_value ? tgt_r[AW-1:0] : idx_r[AW-1:0];
    wdata = cmd.wr_value ? val_r : rdata_r;
  end

  // Report sweep progress and output occupancy; pass the fresh decode
  // through while it is being latched
  always_comb begin
    sts.kind     = cmd.start ? kind_c : kind_r;
    sts.more     = (kind_r == isst_pkg::K_PLACE) ? (idx_r > tgt_r)
                                                 : (idx_inc < {1'b0, count_r});
    sts.out_busy = out_valid_r && !out_ready;
  end

  // Count after the command completes
  always_comb begin
    count_nxt = count_r;
    if (kind_r == isst_pkg::K_PLACE) count_nxt = count_r + 1'b1;
    else if (kind_r == isst_pkg::K_REMOVE) count_nxt = count_r - 1'b1;
  end

  // Element memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    if (ren) rdata_r <= mem[raddr];
  end

  // Hold command fields, decode and sweep index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      pos_r <= in_position;
      val_r <= in_item_value;
    end
    if (cmd.start) begin
      kind_r <= kind_c;
      tgt_r  <= tgt_c[CW-1:0];
      st_r   <= st_c;
      rv_r   <= rv_c;
      idx_r  <= (kind_c == isst_pkg::K_PLACE) ? count_r : tgt_c[CW-1:0];
    end else if (cmd.wr_move) begin
      idx_r <= (kind_r == isst_pkg::K_PLACE) ? idx_r - 1'b1 : idx_inc[CW-1:0];
    end
  end

  // Count and output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_rv_r  <= (kind_r == isst_pkg::K_READ) ? rdata_r : rv_r;
      out_st_r  <= st_r;
      out_cnt_r <= isst_pkg::POS_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_rv_r;
  assign out_status       = out_st_r;
  assign out_stored_count = out_cnt_r;

endmodule

// ----- bench/isst_checker.sv -----
// Scoreboard for the indexed sequence store: watches both item channels,
// predicts each result from a private copy of the sequence, and compares.
// Depends on isst_pkg and the isst_in_if / isst_out_if interfaces.
module isst_checker (
  input  logic        clk,
  input  logic        rst_n,
  isst_in_if          in_mon,
  isst_out_if         out_mon,
  output int unsigned err_count,
  output int unsigned pending_count,
  output int unsigned result_count,
  output int unsigned full_count,
  output int unsigned range_count,
  output int unsigned held_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 40;
  localparam int AW          = isst_pkg::ADDR_W;

  typedef struct packed {
    logic signed [isst_pkg::DATA_W-1:0] read_value;
    logic [isst_pkg::ST_W-1:0]          status;
    logic [isst_pkg::POS_W-1:0]         stored_count;
  } seq_result_t;

  // Private copy of the sequence and its length
  logic signed [isst_pkg::DATA_W-1:0] seq_vals [isst_pkg::CAPACITY];
  int unsigned                        seq_len;

  // Results predicted but not yet seen on the output channel
  seq_result_t pending_results [$];

  int unsigned n_err;
  int unsigned n_res;
  int unsigned n_full;
  int unsigned n_range;

  // Open a slot at pos, shift later values up, store v
  function automatic void place_value(input int unsigned pos,
                                      input logic signed [isst_pkg::DATA_W-1:0] v);
    int unsigned i;
    for (i = seq_len; i > pos; i--)
      seq_vals[AW'(i)] = seq_vals[AW'(i - 1)];
    seq_vals[AW'(pos)] = v;
    seq_len++;
  endfunction

  // Apply one command to the sequence copy and return its result item
  function automatic seq_result_t apply_command(
      input logic [isst_pkg::CMD_W-1:0]         c,
      input logic [isst_pkg::POS_W-1:0]         p,
      input logic signed [isst_pkg::DATA_W-1:0] v);
    seq_result_t res;
    int unsigned pos;
    int unsigned i;
    pos            = 32'(p);
    res.read_value = '0;
    res.status     = isst_pkg::ST_DONE;
    case (c)
      isst_pkg::CMD_READ: begin
        if (pos < seq_len) begin
          res.read_value = seq_vals[AW'(pos)];
        end else begin
          res.read_value = -1;
          res.status     = isst_pkg::ST_RANGE;
        end
      end
      isst_pkg::CMD_ADD_HEAD: begin
        if (seq_len >= isst_pkg::CAPACITY) res.status = isst_pkg::ST_FULL;
        else place_value(0, v);
      end
      isst_pkg::CMD_ADD_TAIL: begin
        if (seq_len >= isst_pkg::CAPACITY) res.status = isst_pkg::ST_FULL;
        else place_value(seq_len, v);
      end
      isst_pkg::CMD_INSERT: begin
        // range test wins over the full test
        if (pos > seq_len) res.status = isst_pkg::ST_RANGE;
        else if (seq_len >= isst_pkg::CAPACITY) res.status = isst_pkg::ST_FULL;
        else place_value(pos, v);
      end
      isst_pkg::CMD_DELETE: begin
        if (pos >= seq_len) begin
          res.status = isst_pkg::ST_RANGE;
        end else begin
          for (i = pos; i + 1 < seq_len; i++)
            seq_vals[AW'(i)] = seq_vals[AW'(i + 1)];
          seq_len--;
        end
      end
      default: begin
        // spare codes leave everything alone
      end
    endcase
    res.stored_count = seq_len[isst_pkg::POS_W-1:0];
    return res;
  endfunction

  task automatic report_field(input string field, input longint want_v,
                              input longint got_v);
    n_err++;
    if (n_err <= MAX_REPORTS)
      $display("%t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    seq_result_t got;
    seq_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      seq_len = 0;
      n_err   = 0;
      n_res   = 0;
      n_full  = 0;
      n_range = 0;
    end else begin
      // Retire the oldest prediction against each delivered result item
      if (out_mon.valid && out_mon.ready) begin
        got.read_value   = out_mon.read_value;
        got.status       = out_mon.status;
        got.stored_count = out_mon.stored_count;
        n_res++;
        if (pending_results.size() == 0) begin
          n_err++;
          if (n_err <= MAX_REPORTS)
            $display("%t: result item with nothing outstanding: value %0d status %0d count %0d",
                     $time, got.read_value, got.status, got.stored_count);
        end else begin
          want = pending_results.pop_front();
          if (want.status == isst_pkg::ST_FULL) n_full++;
          if (want.status == isst_pkg::ST_RANGE) n_range++;
          if (got.read_value !== want.read_value)
            report_field("read_value", 64'(want.read_value), 64'(got.read_value));
          if (got.status !== want.status)
            report_field("status", 64'(want.status), 64'(got.status));
          if (got.stored_count !== want.stored_count)
            report_field("stored_count", 64'(want.stored_count),
                         64'(got.stored_count));
        end
      end
      // Predict the result of each accepted command item
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(apply_command(in_mon.cmd, in_mon.position,
                                                in_mon.item_value));
    end
    err_count     <= n_err;
    result_count  <= n_res;
    full_count    <= n_full;
    range_count   <= n_range;
    pending_count <= pending_results.size();
    held_count    <= seq_len;
  end

endmodule

// ----- bench/indexed_sequence_store_top_tb.sv -----
// Stimulus and verdict for the indexed sequence store: directed edge cases,
// then grow and shrink phases of random commands with random stalls.
// Depends on isst_pkg, the channel interfaces, the RTL top and isst_checker.
module indexed_sequence_store_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RAND_ITEMS   = 1600;
  localparam int          PHASE_LEN    = 200;
  localparam int          STEADY_PHASE = 3;
  localparam int          IDLE_PCT     = 23;
  localparam int          DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int          CW           = isst_pkg::CMD_W;
  localparam int          PW           = isst_pkg::POS_W;
  localparam int          DW           = isst_pkg::DATA_W;

  localparam logic [CW-1:0] CMD_SPARE_FIRST = isst_pkg::CMD_DELETE + 3'd1;
  localparam logic [CW-1:0] CMD_SPARE_LAST  = '1;
  localparam logic [PW-1:0] POS_TOP         = '1;

  localparam logic signed [DW-1:0] V_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] V_MIN  = 32'sh8000_0000;
  localparam logic signed [DW-1:0] V_ALT0 = 32'sh5555_5555;
  localparam logic signed [DW-1:0] V_ALT1 = 32'shAAAA_AAAA;
  localparam logic signed [DW-1:0] V_NEG1 = -32'sd1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 src_valid  = 1'b0;
  logic [CW-1:0]        src_cmd    = isst_pkg::CMD_READ;
  logic [PW-1:0]        src_pos    = '0;
  logic signed [DW-1:0] src_value  = '0;
  logic                 sink_ready = 1'b0;
  logic                 steady     = 1'b0;

  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;

  int unsigned err_count;
  int unsigned pending_count;
  int unsigned result_count;
  int unsigned full_count;
  int unsigned range_count;
  int unsigned held_count;

  isst_in_if  in_ch ();
  isst_out_if out_ch ();

  assign in_ch.valid      = src_valid;
  assign in_ch.cmd        = src_cmd;
  assign in_ch.position   = src_pos;
  assign in_ch.item_value = src_value;
  assign out_ch.ready     = sink_ready;

  indexed_sequence_store_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  isst_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .err_count     (err_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .full_count    (full_count),
    .range_count   (range_count),
    .held_count    (held_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result side at random, except during the steady phase
  always @(posedge clk) begin
    sink_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Hard stop for a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%t: cycle limit reached with %0d results outstanding", $time, pending_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one command item, with optional idle cycles ahead of it
  task automatic send_item(input logic [CW-1:0] c, input logic [PW-1:0] p,
                           input logic signed [DW-1:0] v);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_cmd   <= c;
    src_pos   <= p;
    src_value <= v;
    sent_count++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    int                   n;
    int unsigned          hint;
    int unsigned          r;
    logic                 grow;
    logic [CW-1:0]        c;
    logic [PW-1:0]        p;
    logic signed [DW-1:0] v;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store: every positional command is out of range
    send_item(isst_pkg::CMD_READ,   PW'(0), V_MAX);
    send_item(isst_pkg::CMD_DELETE, PW'(0), V_MAX);
    send_item(isst_pkg::CMD_INSERT, PW'(1), V_MAX);
    send_item(isst_pkg::CMD_INSERT, POS_TOP, V_MAX);
    // Build a short sequence through every way of adding
    send_item(isst_pkg::CMD_INSERT,   PW'(0), V_MAX);
    send_item(isst_pkg::CMD_ADD_HEAD, POS_TOP, V_MIN);
    send_item(isst_pkg::CMD_ADD_TAIL, PW'(0), V_NEG1);
    send_item(isst_pkg::CMD_ADD_TAIL, POS_TOP, '0);
    send_item(isst_pkg::CMD_INSERT,   PW'(4), V_ALT0);
    send_item(isst_pkg::CMD_INSERT,   PW'(2), V_ALT1);
    // Reads at both ends, just past the end and far past it
    send_item(isst_pkg::CMD_READ, PW'(0),  '0);
    send_item(isst_pkg::CMD_READ, PW'(5),  '0);
    send_item(isst_pkg::CMD_READ, PW'(6),  '0);
    send_item(isst_pkg::CMD_READ, POS_TOP, '0);
    send_item(isst_pkg::CMD_READ, PW'(64), '0);
    // Spare codes do nothing
    send_item(CMD_SPARE_FIRST,        POS_TOP, V_NEG1);
    send_item(CMD_SPARE_FIRST + 3'd1, PW'(0),  V_ALT1);
    send_item(CMD_SPARE_LAST,         PW'(3),  V_ALT0);
    // Deletes at head, tail, middle and out of range
    send_item(isst_pkg::CMD_DELETE, PW'(0), '0);
    send_item(isst_pkg::CMD_DELETE, PW'(4), '0);
    send_item(isst_pkg::CMD_DELETE, PW'(2), '0);
    send_item(isst_pkg::CMD_DELETE, PW'(5), '0);
    send_item(isst_pkg::CMD_READ,   PW'(1), '0);

    // Random phases alternate between filling and draining the store
    for (n = 0; n < RAND_ITEMS; n++) begin
      grow = ((n / PHASE_LEN) % 2) == 0;
      steady <= ((n / PHASE_LEN) == STEADY_PHASE);
      hint = held_count;
      r = $urandom_range(0, 99);
      if (r < 25) c = isst_pkg::CMD_READ;
      else if (r < (grow ? 45 : 30)) c = isst_pkg::CMD_ADD_HEAD;
      else if (r < (grow ? 65 : 35)) c = isst_pkg::CMD_ADD_TAIL;
      else if (r < (grow ? 85 : 45)) c = isst_pkg::CMD_INSERT;
      else if (r < (grow ? 95 : 92)) c = isst_pkg::CMD_DELETE;
      else c = CMD_SPARE_LAST
               - CW'($urandom_range(0, 32'(CMD_SPARE_LAST - CMD_SPARE_FIRST)));

      // Mostly legal positions, with a share of arbitrary ones
      if ($urandom_range(0, 9) < 2) p = PW'($urandom_range(0, 32'(POS_TOP)));
      else if (c == isst_pkg::CMD_INSERT) p = PW'($urandom_range(0, hint));
      else if (hint > 0) p = PW'($urandom_range(0, hint - 1));
      else p = PW'($urandom_range(0, 32'(POS_TOP)));

      case ($urandom_range(0, 15))
        0:       v = V_MAX;
        1:       v = V_MIN;
        2:       v = V_NEG1;
        3:       v = '0;
        default: v = $urandom;
      endcase
      send_item(c, p, v);
    end
    src_valid <= 1'b0;
    steady    <= 1'b0;

    // Drain the remaining results, then watch for strays
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands through fill and drain phases, %0d results checked",
             sent_count, result_count);
    $display("Saw %0d full-store drops and %0d out-of-range results, %0d mismatches",
             full_count, range_count, err_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
